// ===== design/bfk_pkg.sv =====
`timescale 1ns / 1ps
package bfk_pkg;

  localparam int KEY_W    = 160;
  localparam int WIN_W    = 40;
  localparam int BIT_BASE = 37;
  localparam int SHORT_W  = 32;
  localparam int CPK_W    = 3;
  localparam int AB_W     = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CPK_W-1:0] CPK_SHORT = 3'd5;
  localparam logic [CPK_W-1:0] CPK_LONG  = 3'd4;
  localparam logic [CPK_W-1:0] CPK_RESET = 3'd5;
  localparam logic [AB_W-1:0]  AB_RESET  = 5'd20;

  localparam logic REG_CPK = 1'b0;
  localparam logic REG_AB  = 1'b1;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [CPK_W-1:0] chunks_per_key;
    logic [AB_W-1:0]  address_bits;
  } bfk_cfg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } bfk_state_t;

endpackage

// ===== design/bfk_if.sv =====
`timescale 1ns / 1ps
interface bfk_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] key_upper;
  logic [63:0] key_middle;
  logic [31:0] key_lower;

  modport source (output valid, output mode, output key_upper, output key_middle,
                  output key_lower, input ready);
  modport sink   (input valid, input mode, input key_upper, input key_middle,
                  input key_lower, output ready);
endinterface

interface bfk_out_if;
  logic       valid;
  logic       ready;
  logic       present;
  logic [2:0] probes;

  modport source (output valid, output present, output probes, input ready);
  modport sink   (input valid, input present, input probes, output ready);
endinterface

// ===== design/bloom_filter_key_add_query.sv =====
`timescale 1ns / 1ps
// channel    dir  handshake     payload
// in_chan    in   valid/ready   mode, key_upper, key_middle, key_lower
// out_chan   out  valid/ready   present, probes
// apb cfg    in   psel/penable  paddr, pwdata, prdata (pready tied high)
//
// an add or a full query runs through accept, one memory read per probe and a
// final check; a query ends at its first clear bit
// an item under an unsupported configuration has its result loaded at accept
// after reset the memory is cleared one byte a cycle, 2**MAX_ADDRESS_BITS
// bytes, and no transaction is accepted until the clear is done
// a new key waits until the previous result is taken or taken in that cycle
module bloom_filter_key_add_query #(
  parameter int MAX_ADDRESS_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bfk_in_if.sink                      in_chan,
  bfk_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfk_pkg::PADDR_W-1:0] paddr,
  input  logic [bfk_pkg::PDATA_W-1:0] pwdata,
  output logic [bfk_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int AW = MAX_ADDRESS_BITS;

  bfk_pkg::bfk_cfg_t   cfg;
  bfk_pkg::bfk_state_t state_r, state_nxt;

  logic [bfk_pkg::KEY_W-1:0] key_r;
  logic                      mode_r;
  logic [2:0]                iss_idx_r, iss_idx_nxt;
  logic                      chk_valid_r, chk_valid_nxt;
  logic [2:0]                chk_idx_r;
  logic [AW-1:0]             chk_addr_r;
  logic [7:0]                chk_bm_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_present_r, out_present_nxt;
  logic [2:0]                out_probes_r, out_probes_nxt;

  logic          cfg_ok;
  logic          in_accept;
  logic          issue;
  logic          hit;
  logic          last;
  logic          miss_stop;
  logic          finish;
  logic [AW-1:0] probe_addr;
  logic [7:0]    probe_bm;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [7:0]    wr_data;
  logic          clr_busy;

  bfk_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bfk_probe_addr #(.AW(AW)) u_probe (
    .key      (key_r),
    .idx      (iss_idx_r),
    .cfg      (cfg),
    .addr     (probe_addr),
    .bit_mask (probe_bm)
  );

  bfk_store #(.AW(AW)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (issue),
    .rd_addr  (probe_addr),
    .wr_en    (wr_en),
    .wr_addr  (chk_addr_r),
    .wr_data  (wr_data),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  assign cfg_ok = ((cfg.chunks_per_key == bfk_pkg::CPK_SHORT) ||
                   (cfg.chunks_per_key == bfk_pkg::CPK_LONG)) &&
                  (cfg.address_bits <= bfk_pkg::AB_W'(MAX_ADDRESS_BITS));

  assign in_chan.ready = (state_r == bfk_pkg::ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_accept     = in_chan.valid && in_chan.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfk_pkg::ST_CLEAR: if (!clr_busy) state_nxt = bfk_pkg::ST_IDLE;
      bfk_pkg::ST_IDLE:  if (in_accept && cfg_ok) state_nxt = bfk_pkg::ST_RUN;
      bfk_pkg::ST_RUN:   if (finish) state_nxt = bfk_pkg::ST_IDLE;
      default:           state_nxt = bfk_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    issue     = (state_r == bfk_pkg::ST_RUN) && (iss_idx_r != cfg.chunks_per_key);
    hit       = (rd_data & chk_bm_r) != 8'h00;
    last      = chk_idx_r == (cfg.chunks_per_key - 3'd1);
    miss_stop = chk_valid_r && (mode_r == bfk_pkg::MODE_QUERY) && !hit;
    finish    = chk_valid_r && (miss_stop || last);
    wr_en     = chk_valid_r && (mode_r == bfk_pkg::MODE_ADD);
    wr_data   = rd_data | chk_bm_r;

    iss_idx_nxt = iss_idx_r;
    if (in_accept) begin
      iss_idx_nxt = 3'd0;
    end else if (issue) begin
      iss_idx_nxt = iss_idx_r + 3'd1;
    end
    chk_valid_nxt = issue && !finish;

    out_valid_nxt   = out_valid_r;
    out_present_nxt = out_present_r;
    out_probes_nxt  = out_probes_r;
    if (in_accept && !cfg_ok) begin
      out_valid_nxt   = 1'b1;
      out_present_nxt = 1'b0;
      out_probes_nxt  = 3'd0;
    end else if (finish) begin
      out_valid_nxt   = 1'b1;
      out_present_nxt = (mode_r == bfk_pkg::MODE_QUERY) && !miss_stop;
      out_probes_nxt  = miss_stop ? 3'(chk_idx_r + 3'd1) : cfg.chunks_per_key;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfk_pkg::ST_CLEAR;
      iss_idx_r   <= 3'd0;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_idx_r   <= iss_idx_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      key_r  <= {in_chan.key_upper, in_chan.key_middle, in_chan.key_lower};
      mode_r <= in_chan.mode;
    end
    chk_idx_r     <= iss_idx_r;
    chk_addr_r    <= probe_addr;
    chk_bm_r      <= probe_bm;
    out_present_r <= out_present_nxt;
    out_probes_r  <= out_probes_nxt;
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.present = out_present_r;
  assign out_chan.probes  = out_probes_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_chan.ready)
    else $error("transaction accepted during memory clear");

  a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r)
    else $error("finished key gave no result");

  a_run_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfk_pkg::ST_RUN) |-> !out_valid_r)
    else $error("result register busy while probing");

  a_check_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    chk_valid_r |-> (state_r == bfk_pkg::ST_RUN))
    else $error("probe check outside of a key");

endmodule

// ===== design/bfk_cfg_regs.sv =====
`timescale 1ns / 1ps
module bfk_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfk_pkg::PADDR_W-1:0]   paddr,
  input  logic [bfk_pkg::PDATA_W-1:0]   pwdata,
  output logic [bfk_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output bfk_pkg::bfk_cfg_t             cfg
);

  logic [bfk_pkg::CPK_W-1:0] cpk_r;
  logic [bfk_pkg::AB_W-1:0]  ab_r;
  logic                      wr_en;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpk_r <= bfk_pkg::CPK_RESET;
      ab_r  <= bfk_pkg::AB_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        bfk_pkg::REG_CPK: cpk_r <= pwdata[bfk_pkg::CPK_W-1:0];
        bfk_pkg::REG_AB:  ab_r  <= pwdata[bfk_pkg::AB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      bfk_pkg::REG_CPK: prdata[bfk_pkg::CPK_W-1:0] = cpk_r;
      bfk_pkg::REG_AB:  prdata[bfk_pkg::AB_W-1:0]  = ab_r;
      default: ;
    endcase
  end

  assign cfg.chunks_per_key = cpk_r;
  assign cfg.address_bits   = ab_r;

endmodule

// ===== design/bfk_probe_addr.sv =====
`timescale 1ns / 1ps
module bfk_probe_addr #(
  parameter int AW = 20
) (
  input  logic [bfk_pkg::KEY_W-1:0] key,
  input  logic [2:0]                idx,
  input  bfk_pkg::bfk_cfg_t         cfg,
  output logic [AW-1:0]             addr,
  output logic [7:0]                bit_mask
);

  logic [bfk_pkg::WIN_W-1:0] win;
  logic [bfk_pkg::WIN_W-1:0] addr_full;
  logic [bfk_pkg::WIN_W-1:0] bit_full;
  logic [5:0]                addr_sh;
  logic [5:0]                bit_sh;
  logic [2:0]                bit_sel;

  // chunk, left aligned in a 40-bit window
  always_comb begin
    win = '0;
    if (cfg.chunks_per_key == bfk_pkg::CPK_SHORT) begin
      case (idx)
        3'd0: win = {key[159:128], 8'h00};
        3'd1: win = {key[127:96],  8'h00};
        3'd2: win = {key[95:64],   8'h00};
        3'd3: win = {key[63:32],   8'h00};
        3'd4: win = {key[31:0],    8'h00};
        default: win = '0;
      endcase
    end else begin
      case (idx)
        3'd0: win = key[159:120];
        3'd1: win = key[119:80];
        3'd2: win = key[79:40];
        3'd3: win = key[39:0];
        default: win = '0;
      endcase
    end
  end

  assign addr_sh   = 6'(bfk_pkg::WIN_W) - {1'b0, cfg.address_bits};
  assign bit_sh    = 6'(bfk_pkg::BIT_BASE) - {1'b0, cfg.address_bits};
  assign addr_full = win >> addr_sh;
  assign bit_full  = win >> bit_sh;
  assign bit_sel   = bit_full[2:0];
  assign addr      = addr_full[AW-1:0];
  assign bit_mask  = 8'b1 << bit_sel;

endmodule

// ===== design/bfk_store.sv =====
`timescale 1ns / 1ps
module bfk_store #(
  parameter int AW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic [7:0]    rd_data,
  output logic          clr_busy
);

  localparam int DEPTH = 1 << AW;

  logic [7:0]  mem [0:DEPTH-1];
  logic [7:0]  rd_q_r;
  logic [AW:0] clr_addr_r;
  logic        fwd_hit_r;
  logic [7:0]  fwd_data_r;

  assign clr_busy = !clr_addr_r[AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (clr_busy) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr_r[AW-1:0]] <= 8'h00;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // a read issued in the same cycle as a write to that byte sees the new value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= rd_en && wr_en && !clr_busy && (rd_addr == wr_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rd_q_r;

endmodule

// ===== tb/bfk_checker.sv =====
`timescale 1ns / 1ps
module bfk_checker
  import bfk_pkg::*;
#(
  parameter int MAX_AB = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  bfk_in_if                  in_mon,
  bfk_out_if                 out_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic       present;
    logic [2:0] probes;
  } lookup_t;

  bfk_cfg_t   cfg;
  // sparse copy of the filter memory, absent bytes read as zero
  logic [7:0] filter_bytes [int];
  lookup_t    expected_lookups [$];

  // sets or tests the probed bits of one key against the filter copy
  function automatic lookup_t lookup_key(logic mode, logic [KEY_W-1:0] digest);
    lookup_t    res;
    int         chunks;
    int         width;
    int         nbits;
    int         addr;
    int         bitn;
    logic [63:0] raw;
    logic [7:0] stored;
    res = '0;
    if (!(cfg.chunks_per_key == CPK_SHORT || cfg.chunks_per_key == CPK_LONG) ||
        int'(cfg.address_bits) > MAX_AB)
      return res;
    chunks = int'(cfg.chunks_per_key);
    width  = (cfg.chunks_per_key == CPK_SHORT) ? SHORT_W : WIN_W;
    nbits  = int'(cfg.address_bits);
    res.probes  = cfg.chunks_per_key;
    res.present = (mode == MODE_QUERY);
    for (int i = 0; i < chunks; i++) begin
      raw  = 64'((digest >> (KEY_W - width * (i + 1))) & ((160'd1 << width) - 1));
      addr = int'((raw >> (width - nbits)) & ((64'd1 << nbits) - 1));
      bitn = int'((raw >> (width - 3 - nbits)) & 64'h7);
      stored = filter_bytes.exists(addr) ? filter_bytes[addr] : 8'h00;
      if (mode == MODE_ADD) begin
        filter_bytes[addr] = stored | (8'h01 << bitn);
      end else if (!stored[bitn]) begin
        res.present = 1'b0;
        res.probes  = 3'(i + 1);
        break;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    lookup_t want;
    if (!rst_n) begin
      errors             = 0;
      cfg.chunks_per_key = CPK_RESET;
      cfg.address_bits   = AB_RESET;
      filter_bytes.delete();
      expected_lookups.delete();
    end else begin
      // paddr bit 2 is the register index
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_CPK: cfg.chunks_per_key = pwdata[CPK_W-1:0];
          REG_AB:  cfg.address_bits   = pwdata[AB_W-1:0];
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_lookups.push_back(lookup_key(in_mon.mode,
          {in_mon.key_upper, in_mon.key_middle, in_mon.key_lower}));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_lookups.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction, present %0d probes %0d",
                   $time, out_mon.present, out_mon.probes);
        end else begin
          want = expected_lookups.pop_front();
          if (out_mon.present !== want.present) begin
            errors++;
            $display("%0t: present mismatch, expected %0d actual %0d",
                     $time, want.present, out_mon.present);
          end
          if (out_mon.probes !== want.probes) begin
            errors++;
            $display("%0t: probes mismatch, expected %0d actual %0d",
                     $time, want.probes, out_mon.probes);
          end
        end
      end
    end
    pending = expected_lookups.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import bfk_pkg::*;

  localparam int MAX_ADDRESS_BITS = 20;
  // the filter memory clear after reset covers 2**MAX_ADDRESS_BITS bytes and counts as idle
  localparam int WATCHDOG_LIMIT   = 4 << MAX_ADDRESS_BITS;
  localparam int DRAIN_CYCLES     = 16;
  localparam int HISTORY_DEPTH    = 64;

  // random phases: config, item count and pacing group
  localparam int N_PHASES = 11;
  localparam int PH_CPK   [N_PHASES] = '{5, 4, 5, 4, 5, 3, 4, 5, 4, 5, 5};
  localparam int PH_AB    [N_PHASES] = '{20, 8, 4, 20, 12, 10, 0, 6, 1, 25, 16};
  localparam int PH_ITEMS [N_PHASES] = '{150, 150, 130, 120, 150, 20, 60, 200, 150, 20, 150};
  localparam int PH_GROUP [N_PHASES] = '{0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2};
  localparam int SEND_IDLE [3] = '{26, 73, 0};
  localparam int RECV_IDLE [3] = '{73, 26, 0};

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 errors;
  int                 pending;
  int                 send_idle;
  int                 recv_idle;
  int                 idle_cycles = 0;
  logic [CPK_W-1:0]   cur_cpk;
  logic [KEY_W-1:0]   added_keys [$];

  bfk_in_if  in_if ();
  bfk_out_if out_if ();

  bloom_filter_key_add_query #(
    .MAX_ADDRESS_BITS(MAX_ADDRESS_BITS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bfk_checker #(
    .MAX_AB(MAX_ADDRESS_BITS)
  ) u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_mon (in_if),
    .out_mon(out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .pready (pready),
    .paddr  (paddr),
    .pwdata (pwdata),
    .errors (errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] random_digest();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // replaces one chunk of the key under the current chunking
  function automatic logic [KEY_W-1:0] with_new_chunk(logic [KEY_W-1:0] digest);
    int               width;
    int               j;
    logic [KEY_W-1:0] field;
    width = (cur_cpk == CPK_LONG) ? WIN_W : SHORT_W;
    j     = $urandom_range(KEY_W / width - 1);
    field = ((160'd1 << width) - 1) << (KEY_W - width * (j + 1));
    return (digest & ~field) | (random_digest() & field);
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_key(input logic mode, input logic [KEY_W-1:0] digest);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.mode       = mode;
    in_if.key_upper  = digest[159:96];
    in_if.key_middle = digest[95:32];
    in_if.key_lower  = digest[31:0];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    if (mode == MODE_ADD) begin
      added_keys.push_back(digest);
      if (added_keys.size() > HISTORY_DEPTH) added_keys.delete(0);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic settle();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // junk in the upper bits, the register keeps only its own width
  task automatic load_config(input int cpk, input int ab);
    settle();
    write_reg(REG_CPK, ($urandom & ~32'h7) | 32'(cpk));
    write_reg(REG_AB, ($urandom & ~32'h1F) | 32'(ab));
    cur_cpk = CPK_W'(cpk);
  endtask

  // mostly keys already added, plain or with one chunk changed, so queries go deep
  task automatic random_items(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (added_keys.size() == 0 || pick < 35)
        send_key(MODE_ADD, random_digest());
      else if (pick < 40)
        send_key(MODE_ADD, added_keys[$urandom_range(added_keys.size() - 1)]);
      else if (pick < 72)
        send_key(MODE_QUERY, added_keys[$urandom_range(added_keys.size() - 1)]);
      else if (pick < 92)
        send_key(MODE_QUERY,
                 with_new_chunk(added_keys[$urandom_range(added_keys.size() - 1)]));
      else
        send_key(MODE_QUERY, random_digest());
    end
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] digest;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_ADD;
    in_if.key_upper  = '0;
    in_if.key_middle = '0;
    in_if.key_lower  = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cur_cpk          = CPK_RESET;
    send_idle        = SEND_IDLE[0];
    recv_idle        = RECV_IDLE[0];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset config, empty filter first
    send_key(MODE_QUERY, '0);
    send_key(MODE_ADD, '0);
    send_key(MODE_QUERY, '0);
    send_key(MODE_QUERY, '1);
    send_key(MODE_ADD, '1);
    send_key(MODE_QUERY, '1);
    // miss on each chunk in turn
    for (int j = 0; j < 5; j++) begin
      digest = '1;
      digest[159 - 32 * j -: 32] = 32'h5A5A_5A5A;
      send_key(MODE_QUERY, digest);
    end
    send_key(MODE_ADD, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'hFFFF_FFFF});
    send_key(MODE_QUERY, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0});

    // 40-bit chunks
    load_config(CPK_LONG, MAX_ADDRESS_BITS);
    send_key(MODE_QUERY, '1);
    send_key(MODE_QUERY, with_new_chunk('1));
    send_key(MODE_ADD, random_digest());

    // unsupported chunk counts
    load_config(7, MAX_ADDRESS_BITS);
    send_key(MODE_ADD, random_digest());
    send_key(MODE_QUERY, '1);
    load_config(0, MAX_ADDRESS_BITS);
    send_key(MODE_QUERY, '0);

    // address wider than the filter
    load_config(CPK_SHORT, MAX_ADDRESS_BITS + 1);
    send_key(MODE_ADD, random_digest());
    load_config(CPK_SHORT, 31);
    send_key(MODE_QUERY, '0);

    // no address bits, everything lands in byte zero
    load_config(CPK_SHORT, 0);
    send_key(MODE_ADD, random_digest());
    send_key(MODE_QUERY, '1);
    send_key(MODE_QUERY, '0);

    for (int p = 0; p < N_PHASES; p++) begin
      load_config(PH_CPK[p], PH_AB[p]);
      send_idle = SEND_IDLE[PH_GROUP[p]];
      recv_idle = RECV_IDLE[PH_GROUP[p]];
      random_items(PH_ITEMS[p]);
    end

    settle();
    if (errors == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
